### rtl/wbm_pkg.sv
package wbm_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam int unsigned CfgDataW = 9;
  localparam logic [CfgDataW-1:0] CFG_DIM_RESET = 9'd256;

  // input item opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // command kinds between front and back
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_ERROR = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    logic       op;
    logic [15:0] pixel_index;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [3:0] window_size;
  } in_word_t;

  typedef struct packed {
    logic [7:0] avg_red;
    logic [7:0] avg_green;
    logic [7:0] avg_blue;
    logic [7:0] valid_count;
    logic       status;
  } out_word_t;

endpackage

### rtl/wbm_front.sv
module wbm_front import wbm_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned MAX_WINDOW = 15
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_word_t            in_data_i,
  input  logic                cmd_full_i,
  output logic                cmd_push_o,
  output logic [2+((MAX_WIDTH*MAX_HEIGHT > 1) ? $clog2(MAX_WIDTH*MAX_HEIGHT) : 1)+24
                + 2*$clog2(MAX_HEIGHT+1) + 2*$clog2(MAX_WIDTH+1)
                + $clog2(MAX_WINDOW+1)-1:0] cmd_o
);

  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned SW = $clog2(MAX_WINDOW + 1);

  typedef struct packed {
    cmd_kind_e       kind;
    logic [AW-1:0]   addr;
    logic [23:0]     pix;
    logic [HW-1:0]   row;
    logic [WW-1:0]   col;
    logic [SW-1:0]   s;
    logic [WW-1:0]   w;
    logic [HW-1:0]   h;
  } cmd_t;

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_e;

  fstate_e       state_q;
  logic [CfgDataW-1:0] cfg_w_q, cfg_h_q;
  cmd_t          cmd_q;
  logic [15:0]   quo_q;
  logic [WW-1:0] rem_q;
  logic [3:0]    step_q;

  logic [WW-1:0] w_sat;
  logic [HW-1:0] h_sat;
  logic [SW-1:0] s_sat;
  logic [31:0]   area;
  logic [WW:0]   trial;
  logic          ge;
  logic [WW-1:0] rem_d;
  logic [15:0]   quo_d;

  // saturate dimensions and window side
  always_comb begin
    if (cfg_w_q == '0) w_sat = WW'(1);
    else if (32'(cfg_w_q) > MAX_WIDTH) w_sat = WW'(MAX_WIDTH);
    else w_sat = WW'(cfg_w_q);
    if (cfg_h_q == '0) h_sat = HW'(1);
    else if (32'(cfg_h_q) > MAX_HEIGHT) h_sat = HW'(MAX_HEIGHT);
    else h_sat = HW'(cfg_h_q);
    if (in_data_i.window_size == '0) s_sat = SW'(1);
    else if (32'(in_data_i.window_size) > MAX_WINDOW) s_sat = SW'(MAX_WINDOW);
    else s_sat = SW'(in_data_i.window_size);
    area = 32'(w_sat) * 32'(h_sat);
  end

  // one restoring step of index / width
  always_comb begin
    trial = {rem_q, quo_q[15]};
    ge    = trial >= {1'b0, cmd_q.w};
    rem_d = ge ? WW'(trial - {1'b0, cmd_q.w}) : WW'(trial);
    quo_d = {quo_q[14:0], ge};
  end

  assign in_ready_o = (state_q == F_IDLE);
  assign cmd_push_o = (state_q == F_PUSH) && !cmd_full_i;
  assign cmd_o      = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cfg_w_q <= CFG_DIM_RESET;
      cfg_h_q <= CFG_DIM_RESET;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_IMAGE_WIDTH:  cfg_w_q <= cfg_data_i;
          CFG_IMAGE_HEIGHT: cfg_h_q <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        F_IDLE: begin
          if (in_valid_i) begin
            cmd_q.addr <= AW'(in_data_i.pixel_index);
            cmd_q.pix  <= {in_data_i.in_red, in_data_i.in_green, in_data_i.in_blue};
            cmd_q.s    <= s_sat;
            cmd_q.w    <= w_sat;
            cmd_q.h    <= h_sat;
            quo_q      <= in_data_i.pixel_index;
            rem_q      <= '0;
            step_q     <= '0;
            if (in_data_i.op == OP_WRITE) begin
              // writes past the store are dropped here
              cmd_q.kind <= CMD_WRITE;
              if (33'(in_data_i.pixel_index) < 33'(Depth)) state_q <= F_PUSH;
            end else if (32'(in_data_i.pixel_index) >= area) begin
              cmd_q.kind <= CMD_ERROR;
              state_q    <= F_PUSH;
            end else begin
              cmd_q.kind <= CMD_QUERY;
              state_q    <= F_DIV;
            end
          end
        end
        F_DIV: begin
          quo_q  <= quo_d;
          rem_q  <= rem_d;
          step_q <= step_q + 4'd1;
          if (step_q == 4'd15) begin
            cmd_q.row <= HW'(quo_d);
            cmd_q.col <= rem_d;
            state_q   <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!cmd_full_i) state_q <= F_IDLE;
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

### rtl/wbm_fifo.sv
module wbm_fifo #(
  parameter int unsigned DW    = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output logic [DW-1:0] data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DW-1:0]  mem_q [DEPTH];
  logic [PW-1:0]  wp_q, rp_q;
  logic [PW:0]    cnt_q;

  assign full_o  = (cnt_q == (PW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  // pointers wrap at the queue depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (32'(wp_q) == DEPTH - 1) ? '0 : wp_q + PW'(1);
      if (pop_i)  rp_q <= (32'(rp_q) == DEPTH - 1) ? '0 : rp_q + PW'(1);
      if (push_i && !pop_i) cnt_q <= cnt_q + (PW+1)'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - (PW+1)'(1);
    end
  end

endmodule

### rtl/wbm_back.sv
module wbm_back import wbm_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned MAX_WINDOW = 15
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_empty_i,
  output logic      cmd_pop_o,
  input  logic [2+((MAX_WIDTH*MAX_HEIGHT > 1) ? $clog2(MAX_WIDTH*MAX_HEIGHT) : 1)+24
               + 2*$clog2(MAX_HEIGHT+1) + 2*$clog2(MAX_WIDTH+1)
               + $clog2(MAX_WINDOW+1)-1:0] cmd_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned SW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SUMW = $clog2(MAX_WINDOW * MAX_WINDOW * 255 + 1);
  localparam int unsigned CNW  = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
  localparam int unsigned STW  = $clog2(SUMW + 1);
  localparam int unsigned RT = HW + SW;
  localparam int unsigned CT = WW + SW;

  typedef struct packed {
    cmd_kind_e       kind;
    logic [AW-1:0]   addr;
    logic [23:0]     pix;
    logic [HW-1:0]   row;
    logic [WW-1:0]   col;
    logic [SW-1:0]   s;
    logic [WW-1:0]   w;
    logic [HW-1:0]   h;
  } cmd_t;

  typedef enum logic [2:0] {B_IDLE, B_WRITE, B_SWEEP, B_DRAIN, B_DIV, B_DONE} bstate_e;

  bstate_e         state_q;
  cmd_t            cmd_q;
  cmd_t            cmd_in;
  logic [SW-1:0]   i_q, j_q;
  logic [SUMW-1:0] sr_q, sg_q, sb_q;
  logic [CNW-1:0]  cnt_q;
  logic            rd_v_q;
  logic [23:0]     rd_q;
  logic [23:0]     mem [Depth];
  logic [CNW:0]    rr_q, rg_q, rb_q;
  logic [STW-1:0]  step_q;
  logic            err_q;
  logic            out_valid_q;
  out_word_t       out_q;

  logic [SW-1:0]   half;
  logic [RT-1:0]   rt;
  logic [CT-1:0]   ct;
  logic            pos_ok;
  logic [AW-1:0]   rd_addr;
  logic            last_pos;
  logic [CNW:0]    tr, tg, tb;
  logic            ger, geg, geb;
  logic            out_load;

  assign cmd_in = cmd_i;

  // window position and its store address
  always_comb begin
    half    = cmd_q.s >> 1;
    rt      = RT'(cmd_q.row) + RT'(i_q);
    ct      = CT'(cmd_q.col) + CT'(j_q);
    pos_ok  = (rt >= RT'(half)) && ((rt - RT'(half)) < RT'(cmd_q.h))
           && (ct >= CT'(half)) && ((ct - CT'(half)) < CT'(cmd_q.w));
    rd_addr = AW'(32'(HW'(rt - RT'(half))) * 32'(cmd_q.w) + 32'(WW'(ct - CT'(half))));
    last_pos = (i_q == cmd_q.s - SW'(1)) && (j_q == cmd_q.s - SW'(1));
  end

  // one restoring step per channel for the three divisions, all by the same count
  always_comb begin
    tr  = {rr_q[CNW-1:0], sr_q[SUMW-1]};
    tg  = {rg_q[CNW-1:0], sg_q[SUMW-1]};
    tb  = {rb_q[CNW-1:0], sb_q[SUMW-1]};
    ger = tr >= {1'b0, cnt_q};
    geg = tg >= {1'b0, cnt_q};
    geb = tb >= {1'b0, cnt_q};
  end

  // pixel store
  always_ff @(posedge clk_i) begin
    if (state_q == B_WRITE) mem[cmd_q.addr] <= cmd_q.pix;
    if (state_q == B_SWEEP && pos_ok) rd_q <= mem[rd_addr];
  end

  assign cmd_pop_o   = (state_q == B_IDLE) && !cmd_empty_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_load    = (state_q == B_DONE) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      rd_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // output word: load a new one or drop the accepted one
      if (out_load) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      rd_v_q <= (state_q == B_SWEEP) && pos_ok;
      // accumulate the word read last cycle
      if (rd_v_q) begin
        sr_q  <= sr_q + SUMW'(rd_q[23:16]);
        sg_q  <= sg_q + SUMW'(rd_q[15:8]);
        sb_q  <= sb_q + SUMW'(rd_q[7:0]);
        cnt_q <= cnt_q + CNW'(1);
      end
      unique case (state_q)
        B_IDLE: begin
          if (!cmd_empty_i) begin
            cmd_q <= cmd_in;
            i_q   <= '0;
            j_q   <= '0;
            sr_q  <= '0;
            sg_q  <= '0;
            sb_q  <= '0;
            cnt_q <= '0;
            err_q <= 1'b0;
            unique case (cmd_in.kind)
              CMD_WRITE: state_q <= B_WRITE;
              CMD_QUERY: state_q <= B_SWEEP;
              default: begin
                err_q   <= 1'b1;
                state_q <= B_DONE;
              end
            endcase
          end
        end
        B_WRITE: state_q <= B_IDLE;
        B_SWEEP: begin
          if (j_q == cmd_q.s - SW'(1)) begin
            j_q <= '0;
            i_q <= i_q + SW'(1);
          end else begin
            j_q <= j_q + SW'(1);
          end
          if (last_pos) state_q <= B_DRAIN;
        end
        B_DRAIN: begin
          rr_q    <= '0;
          rg_q    <= '0;
          rb_q    <= '0;
          step_q  <= '0;
          state_q <= B_DIV;
        end
        B_DIV: begin
          rr_q   <= ger ? (tr - {1'b0, cnt_q}) : tr;
          rg_q   <= geg ? (tg - {1'b0, cnt_q}) : tg;
          rb_q   <= geb ? (tb - {1'b0, cnt_q}) : tb;
          sr_q   <= {sr_q[SUMW-2:0], ger};
          sg_q   <= {sg_q[SUMW-2:0], geg};
          sb_q   <= {sb_q[SUMW-2:0], geb};
          step_q <= step_q + STW'(1);
          if (32'(step_q) == SUMW - 1) state_q <= B_DONE;
        end
        B_DONE: begin
          if (out_load) begin
            if (err_q) begin
              out_q <= '{avg_red: 8'd0, avg_green: 8'd0, avg_blue: 8'd0,
                         valid_count: 8'd0, status: 1'b1};
            end else begin
              out_q <= '{avg_red: 8'(sr_q), avg_green: 8'(sg_q), avg_blue: 8'(sb_q),
                         valid_count: 8'(cnt_q), status: 1'b0};
            end
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

### rtl/window_box_mean_edge_normalized.sv
// channel   dir  handshake             word
// cfg       in   cfg_we_i              cfg_idx_i, cfg_data_i
// in        in   in_valid_i/in_ready_o in_data_i (in_word_t)
// out       out  out_valid_o/out_ready_i out_data_o (out_word_t)
//
// Write: the front takes the word and pushes it, then the back writes the
// store. Query: the front runs a 16-step index/width divider, then the back,
// where the single store read port walks the window and three serial
// dividers, one per channel, form SUMW-bit quotients (SUMW = 16 at default sizes).
// Reset clears control only; the pixel store holds garbage until written.
// A 4-entry command queue lets the front accept while the back works or the
// output register waits for out_ready_i.
module window_box_mean_edge_normalized import wbm_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned MAX_WINDOW = 15
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_word_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_word_t           out_data_o
);

  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = 2 + AW + 24 + 2 * $clog2(MAX_HEIGHT + 1)
                             + 2 * $clog2(MAX_WIDTH + 1) + $clog2(MAX_WINDOW + 1);

  logic          push, full, pop, empty;
  logic [CW-1:0] cmd_wr, cmd_rd;

  wbm_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_WINDOW(MAX_WINDOW))
  u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .in_data_i,
    .cmd_full_i(full), .cmd_push_o(push), .cmd_o(cmd_wr)
  );

  wbm_fifo #(.DW(CW), .DEPTH(4)) u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(cmd_wr), .full_o(full),
    .pop_i(pop), .empty_o(empty), .data_o(cmd_rd)
  );

  wbm_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_WINDOW(MAX_WINDOW))
  u_back (
    .clk_i, .rst_ni, .cmd_empty_i(empty), .cmd_pop_o(pop), .cmd_i(cmd_rd),
    .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule

### sim/tb_window_box_mean_edge_normalized.sv
module tb_window_box_mean_edge_normalized;
  import wbm_pkg::*;

  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned DrainCycles = 300;
  localparam int unsigned SettleCycles = 40;

  // one row of the directed table
  typedef struct {
    in_word_t  word;
    bit        known;
    out_word_t mean;
  } dir_row_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  logic                in_valid;
  logic                in_ready;
  in_word_t            in_word;
  logic                out_valid;
  logic                out_ready;
  out_word_t           out_word;

  // predictor state
  logic [23:0]   pixel_mem [65536];
  int unsigned   img_w;
  int unsigned   img_h;
  out_word_t     mean_q[$];
  int unsigned   errors;
  int unsigned   results_seen;
  int unsigned   cycles;
  bit            no_gaps;
  dir_row_t      dir_rows[$];

  window_box_mean_edge_normalized u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // edge-normalized box mean for one query word
  function automatic out_word_t box_mean(in_word_t w);
    out_word_t   r;
    int unsigned s, half, row, col, rr, cc, cnt, sr, sg, sb;
    logic [23:0] p;
    r = '0;
    s = clamp_dim(w.window_size, 15);
    if (w.pixel_index >= img_w * img_h) begin
      r.status = 1'b1;
      return r;
    end
    half = s / 2;
    row = w.pixel_index / img_w;
    col = w.pixel_index % img_w;
    cnt = 0; sr = 0; sg = 0; sb = 0;
    for (int unsigned i = 0; i < s; i++) begin
      if (row + i < half) continue;
      rr = row + i - half;
      if (rr >= img_h) continue;
      for (int unsigned j = 0; j < s; j++) begin
        if (col + j < half) continue;
        cc = col + j - half;
        if (cc >= img_w) continue;
        p = pixel_mem[rr * img_w + cc];
        sr += p[23:16];
        sg += p[15:8];
        sb += p[7:0];
        cnt++;
      end
    end
    r.avg_red = 8'(sr / cnt);
    r.avg_green = 8'(sg / cnt);
    r.avg_blue = 8'(sb / cnt);
    r.valid_count = 8'(cnt);
    return r;
  endfunction

  // offer one word; the expectation is booked once acceptance is certain
  task automatic send_word(in_word_t w, bit known, out_word_t typed);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    if (w.op == OP_WRITE) begin
      pixel_mem[w.pixel_index] = {w.in_red, w.in_green, w.in_blue};
    end else begin
      mean_q = {mean_q, (known ? typed : box_mean(w))};
    end
    @(posedge clk);
  endtask

  // wait for the block to drain, then write the image size
  task automatic set_dims(logic [CfgDataW-1:0] wv, logic [CfgDataW-1:0] hv);
    in_valid <= 1'b0;
    while (mean_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_IMAGE_WIDTH;
    cfg_data <= wv;
    @(posedge clk);
    cfg_idx <= CFG_IMAGE_HEIGHT;
    cfg_data <= hv;
    @(posedge clk);
    // unused index must be ignored
    cfg_idx <= CfgIdxW'(2 + $urandom_range(0, 1));
    cfg_data <= CfgDataW'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    img_w = clamp_dim(wv, 256);
    img_h = clamp_dim(hv, 256);
    @(posedge clk);
  endtask

  function automatic in_word_t pix_word(int unsigned idx, logic [7:0] r, logic [7:0] g,
                                        logic [7:0] b);
    in_word_t w;
    w = in_word_t'($urandom);
    w.op = OP_WRITE;
    w.pixel_index = 16'(idx);
    w.in_red = r;
    w.in_green = g;
    w.in_blue = b;
    return w;
  endfunction

  function automatic in_word_t query_word(int unsigned idx, logic [3:0] s);
    in_word_t w;
    w = in_word_t'({$urandom, $urandom});
    w.op = OP_QUERY;
    w.pixel_index = 16'(idx);
    w.window_size = s;
    return w;
  endfunction

  function automatic dir_row_t row_of(in_word_t w, bit known, out_word_t m);
    dir_row_t d;
    d.word = w;
    d.known = known;
    d.mean = m;
    return d;
  endfunction

  // fill the whole image so no query can touch an unwritten pixel
  task automatic fill_image();
    for (int unsigned i = 0; i < img_w * img_h; i++) begin
      send_word(pix_word(i, 8'($urandom), 8'($urandom), 8'($urandom)), 1'b0, '0);
    end
  endtask

  // stimulus
  initial begin
    out_word_t   full, fail_word;
    int unsigned wv, hv, n_q, pick;
    in_word_t    w;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_word = '0;
    out_ready = 1'b0;
    errors = 0;
    cycles = 0;
    no_gaps = 1'b0;
    img_w = 256;
    img_h = 256;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: 2x2 image with extreme colors
    full = '{avg_red: 8'd255, avg_green: 8'd255, avg_blue: 8'd255, valid_count: 8'd1,
             status: 1'b0};
    fail_word = '0;
    fail_word.status = 1'b1;
    dir_rows = {dir_rows, row_of(pix_word(0, 8'hff, 8'hff, 8'hff), 1'b0, '0)};
    dir_rows = {dir_rows, row_of(pix_word(1, 8'h00, 8'h00, 8'h00), 1'b0, '0)};
    dir_rows = {dir_rows, row_of(pix_word(2, 8'hff, 8'h00, 8'hff), 1'b0, '0)};
    dir_rows = {dir_rows, row_of(pix_word(3, 8'h00, 8'hff, 8'h00), 1'b0, '0)};
    dir_rows = {dir_rows, row_of(pix_word(65535, 8'hff, 8'hff, 8'hff), 1'b0, '0)};
    dir_rows = {dir_rows, row_of(query_word(0, 4'd1), 1'b1, full)};
    dir_rows = {dir_rows, row_of(query_word(0, 4'd0), 1'b1, full)};
    dir_rows = {dir_rows, row_of(query_word(3, 4'd15), 1'b0, '0)};
    dir_rows = {dir_rows, row_of(query_word(1, 4'd2), 1'b0, '0)};
    dir_rows = {dir_rows, row_of(query_word(2, 4'd3), 1'b0, '0)};
    dir_rows = {dir_rows, row_of(query_word(3, 4'd14), 1'b0, '0)};
    dir_rows = {dir_rows, row_of(query_word(4, 4'd5), 1'b1, fail_word)};
    dir_rows = {dir_rows, row_of(query_word(65535, 4'd15), 1'b1, fail_word)};
    set_dims(9'd2, 9'd2);
    foreach (dir_rows[i]) send_word(dir_rows[i].word, dir_rows[i].known, dir_rows[i].mean);

    // random phases, extremes of the size registers among them
    for (int ph = 0; ph < 24; ph++) begin
      case (ph)
        1: begin wv = 256; hv = 1; end
        2: begin wv = 1; hv = 256; end
        3: begin wv = 0; hv = 0; end
        4: begin wv = 511; hv = 1; end
        5: begin wv = 1; hv = 511; end
        default: begin wv = $urandom_range(1, 10); hv = $urandom_range(1, 10); end
      endcase
      set_dims(CfgDataW'(wv), CfgDataW'(hv));
      no_gaps = ($urandom_range(0, 3) == 0);
      fill_image();
      n_q = 10;
      for (int k = 0; k < n_q; k++) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          w = query_word($urandom_range(0, img_w * img_h - 1), 4'($urandom));
        end else if (pick < 8) begin
          w = query_word($urandom_range(img_w * img_h, 65535), 4'($urandom));
        end else begin
          // rewrite inside the image or store anywhere
          w = pix_word($urandom_range(0, 1) ? $urandom_range(0, img_w * img_h - 1)
                                            : $urandom_range(0, 65535),
                       8'($urandom), 8'($urandom), 8'($urandom));
        end
        send_word(w, 1'b0, '0);
      end
    end

    // drain
    in_valid <= 1'b0;
    while (mean_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // result side: random stalls plus one long hold-off to fill the block
  initial begin
    int unsigned gap;
    out_word_t   exp_w;
    results_seen = 0;
    @(posedge rst_n);
    forever begin
      if (results_seen == 30) gap = 1500;
      else if ($urandom_range(0, 3) == 0) gap = 0;
      else gap = $urandom_range(0, 18);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      forever begin
        @(negedge clk);
        if (out_valid) break;
      end
      if (mean_q.size() == 0) begin
        $display("%0t: unexpected word %p", $time, out_word);
        errors++;
      end else begin
        exp_w = mean_q.pop_front();
        if (out_word.avg_red !== exp_w.avg_red) begin
          $display("%0t: avg_red exp %0d got %0d", $time, exp_w.avg_red, out_word.avg_red);
          errors++;
        end
        if (out_word.avg_green !== exp_w.avg_green) begin
          $display("%0t: avg_green exp %0d got %0d", $time, exp_w.avg_green,
                   out_word.avg_green);
          errors++;
        end
        if (out_word.avg_blue !== exp_w.avg_blue) begin
          $display("%0t: avg_blue exp %0d got %0d", $time, exp_w.avg_blue, out_word.avg_blue);
          errors++;
        end
        if (out_word.valid_count !== exp_w.valid_count) begin
          $display("%0t: valid_count exp %0d got %0d", $time, exp_w.valid_count,
                   out_word.valid_count);
          errors++;
        end
        if (out_word.status !== exp_w.status) begin
          $display("%0t: status exp %0d got %0d", $time, exp_w.status, out_word.status);
          errors++;
        end
      end
      results_seen++;
      @(posedge clk);
    end
  end

endmodule
